>>> rtl/core/bdlp_pkg.sv
// bdlp_pkg: shared types, codes and reset values for the button debouncer
// with long-press detection; used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // field widths
  localparam int LevelsW = 5;
  localparam int CodeW   = 4;
  localparam int TimerW  = 10;
  localparam int ChecksW = 4;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  // register reset values
  localparam logic [TimerW-1:0]  BOUNCE_RESET = 10'd50;
  localparam logic [TimerW-1:0]  REPEAT_RESET = 10'd100;
  localparam logic [ChecksW-1:0] LONG_RESET   = 4'd5;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_BOUNCE = 2'd0;
  localparam logic [1:0] REG_REPEAT = 2'd1;
  localparam logic [1:0] REG_LONG   = 2'd2;

  // key event codes
  localparam logic [CodeW-1:0] EV_NONE        = 4'd0;
  localparam logic [CodeW-1:0] EV_RIGHT       = 4'd1;
  localparam logic [CodeW-1:0] EV_CENTER      = 4'd2;
  localparam logic [CodeW-1:0] EV_CENTER_HOLD = 4'd3;
  localparam logic [CodeW-1:0] EV_LEFT        = 4'd4;
  localparam logic [CodeW-1:0] EV_ENC         = 4'd5;
  localparam logic [CodeW-1:0] EV_ENC_HOLD    = 4'd6;
  localparam logic [CodeW-1:0] EV_MODE        = 4'd7;
  localparam logic [CodeW-1:0] EV_MODE_HOLD   = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BOUNCE = 2'd1,
    PH_CHECK  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TimerW-1:0]  bounce_ticks;
    logic [TimerW-1:0]  repeat_ticks;
    logic [ChecksW-1:0] long_press_checks;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [CodeW-1:0]   latched_code;
    logic [TimerW-1:0]  wait_timer;
    logic [ChecksW-1:0] held_checks;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_IDLE,
    latched_code: EV_NONE,
    wait_timer:   '0,
    held_checks:  '0
  };

endpackage

`default_nettype wire

>>> rtl/core/bdlp_regs.sv
// bdlp_regs: configuration registers behind the apb-style port
// depends on bdlp_pkg for the register map and reset values
`timescale 1ns / 1ps
`default_nettype none

module bdlp_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [1:0]                 reg_index,
  input  wire logic [bdlp_pkg::DataW-1:0] pwdata,
  output logic      [bdlp_pkg::DataW-1:0] prdata,
  output logic                            pready,
  output bdlp_pkg::cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bounce_ticks      <= bdlp_pkg::BOUNCE_RESET;
      cfg.repeat_ticks      <= bdlp_pkg::REPEAT_RESET;
      cfg.long_press_checks <= bdlp_pkg::LONG_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        bdlp_pkg::REG_BOUNCE: cfg.bounce_ticks <= pwdata[bdlp_pkg::TimerW-1:0];
        bdlp_pkg::REG_REPEAT: cfg.repeat_ticks <= pwdata[bdlp_pkg::TimerW-1:0];
        bdlp_pkg::REG_LONG:   cfg.long_press_checks <= pwdata[bdlp_pkg::ChecksW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      bdlp_pkg::REG_BOUNCE: prdata[bdlp_pkg::TimerW-1:0] = cfg.bounce_ticks;
      bdlp_pkg::REG_REPEAT: prdata[bdlp_pkg::TimerW-1:0] = cfg.repeat_ticks;
      bdlp_pkg::REG_LONG:   prdata[bdlp_pkg::ChecksW-1:0] = cfg.long_press_checks;
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/bdlp_step.sv
// bdlp_step: one-tick state update of the debounce and long-press machine
// depends on bdlp_pkg for the state, config and key code definitions
`timescale 1ns / 1ps
`default_nettype none

module bdlp_step (
  input  wire bdlp_pkg::state_t             st,
  input  wire logic [bdlp_pkg::LevelsW-1:0] levels,
  input  wire bdlp_pkg::cfg_t               cfg,
  output bdlp_pkg::state_t                  st_next,
  output logic      [bdlp_pkg::CodeW-1:0]   step_code
);

  logic                          expired;
  logic                          released;
  logic [bdlp_pkg::TimerW-1:0]   timer_dec;
  logic [bdlp_pkg::CodeW-1:0]    picked;

  // wait expires when at most one tick is left
  assign expired   = (st.wait_timer <= bdlp_pkg::TimerW'(1));
  assign timer_dec = st.wait_timer - bdlp_pkg::TimerW'(1);
  assign released  = (levels == '0);

  // fixed priority: right, center, left, encoder, mode
  always_comb begin
    if (levels[0])      picked = bdlp_pkg::EV_RIGHT;
    else if (levels[1]) picked = bdlp_pkg::EV_CENTER;
    else if (levels[2]) picked = bdlp_pkg::EV_LEFT;
    else if (levels[3]) picked = bdlp_pkg::EV_ENC;
    else if (levels[4]) picked = bdlp_pkg::EV_MODE;
    else                picked = bdlp_pkg::EV_NONE;
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st.phase)
      bdlp_pkg::PH_BOUNCE: begin
        if (!expired) begin
          st_next.wait_timer = timer_dec;
        end else if (released) begin
          st_next.wait_timer = '0;
          st_next.phase      = bdlp_pkg::PH_IDLE;
        end else begin
          st_next.phase       = bdlp_pkg::PH_CHECK;
          st_next.wait_timer  = cfg.repeat_ticks;
          st_next.held_checks = '0;
        end
      end
      bdlp_pkg::PH_CHECK: begin
        if (!expired) begin
          st_next.wait_timer = timer_dec;
        end else if (released) begin
          st_next.wait_timer = '0;
          st_next.phase      = bdlp_pkg::PH_IDLE;
        end else begin
          // count held checks, then promote to the long code
          if (st.held_checks < cfg.long_press_checks) begin
            st_next.held_checks = st.held_checks + bdlp_pkg::ChecksW'(1);
          end else if (st.latched_code == bdlp_pkg::EV_CENTER ||
                       st.latched_code == bdlp_pkg::EV_ENC ||
                       st.latched_code == bdlp_pkg::EV_MODE) begin
            st_next.latched_code = st.latched_code + bdlp_pkg::CodeW'(1);
          end
          st_next.wait_timer = cfg.repeat_ticks;
        end
      end
      default: begin
        // idle, and the unused code that behaves as idle
        st_next.phase = bdlp_pkg::PH_IDLE;
        if (!released) begin
          st_next.latched_code = picked;
          st_next.wait_timer   = cfg.bounce_ticks;
          st_next.phase        = bdlp_pkg::PH_BOUNCE;
        end
      end
    endcase
  end

  // output: a release when the check wait expires emits the latched key
  always_comb begin
    step_code = bdlp_pkg::EV_NONE;
    unique case (st.phase)
      bdlp_pkg::PH_CHECK: begin
        if (expired && released) step_code = st.latched_code;
      end
      default: step_code = bdlp_pkg::EV_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_long_press_core.sv
// button_debounce_long_press_core: top level, one millisecond tick per request
// depends on bdlp_pkg, bdlp_regs and bdlp_step
// an accepted request waits in the input register; the result register loads from it when the pipeline advances
// throughput: one request per cycle while the result register is free or drained; input register, state update,
// result register; reset (rst, synchronous): pipeline empty, phase idle, timers and counts zero,
//   registers at bounce 50, repeat 100, long-press checks 5
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bdlp_pkg::LevelsW-1:0] button_levels,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bdlp_pkg::CodeW-1:0]   key_event,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bdlp_pkg::AddrW-1:0]   paddr,
  input  wire logic [bdlp_pkg::DataW-1:0]   pwdata,
  output logic      [bdlp_pkg::DataW-1:0]   prdata,
  output logic                              pready
);

  bdlp_pkg::cfg_t                  cfg;
  bdlp_pkg::state_t                st;
  bdlp_pkg::state_t                st_next;
  logic                            s1_valid;
  logic [bdlp_pkg::LevelsW-1:0]    levels_q;
  logic [bdlp_pkg::CodeW-1:0]      step_code;
  logic                            advance;

  // configuration registers
  bdlp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .reg_index (paddr[3:2]),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg)
  );

  // pipeline moves when the result register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      levels_q <= button_levels;
    end
  end

  // state update for the registered tick
  bdlp_step u_step (
    .st        (st),
    .levels    (levels_q),
    .cfg       (cfg),
    .st_next   (st_next),
    .step_code (step_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= bdlp_pkg::STATE_RESET;
    end else if (advance && s1_valid) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      key_event <= step_code;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bdlp_checker.sv
// bdlp_checker: port-level assertions for the debounce core, bound to the top
// depends on bdlp_pkg for widths and key codes
`timescale 1ns / 1ps
`default_nettype none

module bdlp_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [bdlp_pkg::CodeW-1:0]   key_event,
  input wire logic [bdlp_pkg::DataW-1:0]   prdata,
  input wire logic                         pready
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_event))
    else $error("result changed while stalled");

  // only defined key codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_event <= bdlp_pkg::EV_MODE_HOLD)
    else $error("undefined key code");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // registers read back no bits above the timer width
  a_prdata_width: assert property (@(posedge clk) disable iff (rst)
    pready && prdata[bdlp_pkg::DataW-1:bdlp_pkg::TimerW] == '0)
    else $error("read data wider than any register");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .key_event (key_event),
  .prdata    (prdata),
  .pready    (pready)
);

`default_nettype wire

>>> tb/button_debounce_long_press_core_tb.sv
// testbench for button_debounce_long_press_core: directed and random tick streams checked
// against a cycle-free key predictor held in a small scoreboard class
// depends on bdlp_pkg and the rtl/core sources
`timescale 1ns / 1ps

module button_debounce_long_press_core_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LONG_STALL = 300;

  // key predictor and expected-key store
  class key_scoreboard;
    logic [bdlp_pkg::TimerW-1:0]  bounce_cfg;
    logic [bdlp_pkg::TimerW-1:0]  repeat_cfg;
    logic [bdlp_pkg::ChecksW-1:0] long_cfg;
    bdlp_pkg::phase_t             step_phase;
    logic [bdlp_pkg::CodeW-1:0]   latched_key;
    logic [bdlp_pkg::TimerW-1:0]  wait_count;
    logic [bdlp_pkg::ChecksW-1:0] held_count;
    logic [bdlp_pkg::CodeW-1:0]   expected_keys[$];
    int unsigned                  requests_seen;
    int unsigned                  results_seen;
    int unsigned                  key_events;
    int unsigned                  long_events;
    int unsigned                  errors;

    function new();
      bounce_cfg    = bdlp_pkg::BOUNCE_RESET;
      repeat_cfg    = bdlp_pkg::REPEAT_RESET;
      long_cfg      = bdlp_pkg::LONG_RESET;
      step_phase    = bdlp_pkg::PH_IDLE;
      latched_key   = bdlp_pkg::EV_NONE;
      wait_count    = '0;
      held_count    = '0;
      requests_seen = 0;
      results_seen  = 0;
      key_events    = 0;
      long_events   = 0;
      errors        = 0;
    endfunction

    function void write_register(input logic [1:0] idx,
                                 input logic [bdlp_pkg::DataW-1:0] value);
      case (idx)
        bdlp_pkg::REG_BOUNCE: bounce_cfg = value[bdlp_pkg::TimerW-1:0];
        bdlp_pkg::REG_REPEAT: repeat_cfg = value[bdlp_pkg::TimerW-1:0];
        bdlp_pkg::REG_LONG:   long_cfg   = value[bdlp_pkg::ChecksW-1:0];
        default: ;
      endcase
    endfunction

    // priority: right, center, left, encoder, mode
    function logic [bdlp_pkg::CodeW-1:0] first_pressed(
        input logic [bdlp_pkg::LevelsW-1:0] levels);
      if (levels[0]) return bdlp_pkg::EV_RIGHT;
      if (levels[1]) return bdlp_pkg::EV_CENTER;
      if (levels[2]) return bdlp_pkg::EV_LEFT;
      if (levels[3]) return bdlp_pkg::EV_ENC;
      if (levels[4]) return bdlp_pkg::EV_MODE;
      return bdlp_pkg::EV_NONE;
    endfunction

    // one tick of the running wait, a zero count expires at once
    function bit wait_expired();
      if (wait_count <= 1) begin
        wait_count = '0;
        return 1'b1;
      end
      wait_count = wait_count - 1'b1;
      return 1'b0;
    endfunction

    function void note_request(input logic [bdlp_pkg::LevelsW-1:0] levels);
      logic [bdlp_pkg::CodeW-1:0] key;
      key = bdlp_pkg::EV_NONE;
      case (step_phase)
        bdlp_pkg::PH_BOUNCE: begin
          if (wait_expired()) begin
            if (levels == '0) begin
              step_phase = bdlp_pkg::PH_IDLE;
            end else begin
              step_phase = bdlp_pkg::PH_CHECK;
              wait_count = repeat_cfg;
              held_count = '0;
            end
          end
        end
        bdlp_pkg::PH_CHECK: begin
          if (wait_expired()) begin
            if (levels == '0) begin
              step_phase = bdlp_pkg::PH_IDLE;
              key = latched_key;
            end else begin
              // count held checks, then promote to the long code
              if (held_count < long_cfg) begin
                held_count = held_count + 1'b1;
              end else if (latched_key == bdlp_pkg::EV_CENTER ||
                           latched_key == bdlp_pkg::EV_ENC ||
                           latched_key == bdlp_pkg::EV_MODE) begin
                latched_key = latched_key + 1'b1;
              end
              wait_count = repeat_cfg;
            end
          end
        end
        default: begin
          step_phase = bdlp_pkg::PH_IDLE;
          if (levels != '0) begin
            latched_key = first_pressed(levels);
            wait_count  = bounce_cfg;
            step_phase  = bdlp_pkg::PH_BOUNCE;
          end
        end
      endcase
      expected_keys.push_back(key);
      requests_seen++;
    endfunction

    function void check_result(input logic [bdlp_pkg::CodeW-1:0] key);
      logic [bdlp_pkg::CodeW-1:0] want;
      if (expected_keys.size() == 0) begin
        $error("key_event arrived with nothing expected, actual %0d", key);
        errors++;
        return;
      end
      want = expected_keys.pop_front();
      results_seen++;
      if (key !== want) begin
        $error("key_event mismatch: expected %0d, actual %0d", want, key);
        errors++;
      end
      if (want != bdlp_pkg::EV_NONE) key_events++;
      if (want == bdlp_pkg::EV_CENTER_HOLD || want == bdlp_pkg::EV_ENC_HOLD ||
          want == bdlp_pkg::EV_MODE_HOLD)
        long_events++;
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [bdlp_pkg::LevelsW-1:0]  button_levels;
  logic                          out_valid;
  logic                          out_ready;
  logic [bdlp_pkg::CodeW-1:0]    key_event;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bdlp_pkg::AddrW-1:0]    paddr;
  logic [bdlp_pkg::DataW-1:0]    pwdata;
  logic [bdlp_pkg::DataW-1:0]    prdata;
  logic                          pready;

  key_scoreboard                 sb = new();
  logic [bdlp_pkg::LevelsW-1:0]  tick_queue[$];
  int unsigned                   settings_run;
  int unsigned                   idle_cycles = 0;

  button_debounce_long_press_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .button_levels (button_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_event     (key_event),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(key_event);
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout after %0d cycles without progress", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: changing stall patterns, with one long hold-off after 80 results
  initial begin : result_sink
    int unsigned cycle_count;
    int unsigned rx_mode;
    bit          long_stall_done;
    cycle_count     = 0;
    rx_mode         = 0;
    long_stall_done = 1'b0;
    out_ready       = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_stall_done && sb.results_seen >= 80) begin
        long_stall_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      if (cycle_count % 48 == 0) rx_mode = $urandom_range(0, 3);
      cycle_count++;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (cycle_count % 4 != 0);
        default: out_ready <= (cycle_count % 4 == 0);
      endcase
    end
  end

  // register write: setup phase, then access phase until pready
  task automatic apb_write(input logic [1:0] idx, input int unsigned value);
    logic [bdlp_pkg::DataW-1:0] field_mask;
    field_mask = (idx == bdlp_pkg::REG_LONG) ? bdlp_pkg::DataW'(4'hF)
                                             : bdlp_pkg::DataW'(10'h3FF);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bdlp_pkg::AddrW'({idx, 2'b00});
    // junk above the field width must be dropped
    pwdata  <= (bdlp_pkg::DataW'(value) & field_mask) |
               (bdlp_pkg::DataW'($urandom) & ~field_mask);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, bdlp_pkg::DataW'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_registers(input int unsigned b, input int unsigned r,
                                   input int unsigned l);
    apb_write(bdlp_pkg::REG_BOUNCE, b);
    apb_write(bdlp_pkg::REG_REPEAT, r);
    apb_write(bdlp_pkg::REG_LONG, l);
    settings_run++;
  endtask

  // one random sequence: mostly a full press, some glitches and noise
  function automatic void add_sequence(input int unsigned b, input int unsigned r,
                                       input int unsigned l);
    int unsigned b_eff, r_eff, hold, rest, kind;
    b_eff = (b == 0) ? 1 : b;
    r_eff = (r == 0) ? 1 : r;
    kind  = $urandom_range(0, 9);
    if (kind < 7) begin
      hold = b_eff + $urandom_range(0, l + 3) * r_eff + $urandom_range(0, r_eff - 1);
      if (hold > 150) hold = $urandom_range(1, 150);
      rest = r_eff + 1;
      if (rest > 40) rest = $urandom_range(1, 40);
      repeat (hold) tick_queue.push_back(bdlp_pkg::LevelsW'($urandom_range(1, 31)));
      repeat (rest) tick_queue.push_back('0);
    end else if (kind == 7) begin
      hold = $urandom_range(1, (b_eff > 40) ? 40 : b_eff);
      rest = (b_eff + 1 > 40) ? 40 : b_eff + 1;
      repeat (hold) tick_queue.push_back(bdlp_pkg::LevelsW'($urandom_range(1, 31)));
      repeat (rest) tick_queue.push_back('0);
    end else begin
      repeat ($urandom_range(1, 8))
        tick_queue.push_back(bdlp_pkg::LevelsW'($urandom_range(0, 31)));
    end
  endfunction

  // tick sender: bursts of random length with random gaps
  task automatic send_ticks();
    int unsigned burst_left;
    int unsigned gap;
    logic [bdlp_pkg::LevelsW-1:0] levels;
    burst_left = 0;
    while (tick_queue.size() != 0) begin
      levels = tick_queue.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      in_valid      <= 1'b1;
      button_levels <= levels;
      do @(posedge clk); while (!in_ready);
      sb.note_request(levels);
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // hold the sender until every expected key has come back
  task automatic drain();
    while (sb.expected_keys.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned b, input int unsigned r,
                           input int unsigned l, input int unsigned n);
    program_registers(b, r, l);
    while (tick_queue.size() < n) add_sequence(b, r, l);
    // keep the tick count of each phase as planned
    while (tick_queue.size() > n) void'(tick_queue.pop_back());
    send_ticks();
    drain();
  endtask

  initial begin : stimulus
    logic [bdlp_pkg::LevelsW-1:0] buttons[5];
    rst           = 1'b1;
    in_valid      = 1'b0;
    button_levels = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    settings_run  = 0;
    buttons       = '{5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b10000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero waits act as one tick, zero long-press checks
    // promote at the first held check, right and left stay short
    program_registers(0, 0, 0);
    foreach (buttons[i]) begin
      repeat (3) tick_queue.push_back(buttons[i]);
      tick_queue.push_back('0);
    end
    // all buttons pressed latches right, then a glitch released in bounce
    tick_queue.push_back(5'b11111);
    tick_queue.push_back(5'b11111);
    tick_queue.push_back(5'b00000);
    tick_queue.push_back(5'b00100);
    tick_queue.push_back(5'b00000);
    send_ticks();
    drain();

    // reset values, with the long result stall landing in here
    run_phase(50, 100, 5, 250);
    run_phase(1, 1, 0, 100);
    run_phase(2, 3, 15, 120);
    run_phase(1023, 1023, 15, 60);
    run_phase(1, 1023, 3, 60);
    run_phase(1023, 1, 1, 60);
    run_phase(3, 2, 4, 120);
    run_phase(0, 0, 2, 80);
    repeat (4) run_phase($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 15), 110);

    if (sb.expected_keys.size() != 0) begin
      $error("%0d key_event results never arrived", sb.expected_keys.size());
      sb.errors++;
    end
    $display("covered %0d ticks under %0d register settings", sb.requests_seen, settings_run);
    $display("%0d keys reported, %0d of them long presses", sb.key_events, sb.long_events);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_regs.sv
rtl/core/bdlp_step.sv
rtl/core/button_debounce_long_press_core.sv
rtl/core/bdlp_checker.sv
tb/button_debounce_long_press_core_tb.sv
